// ===== hdl/lkc_pkg.sv =====
// Package for the LRU keyed entry cache: operation codes, sequencer states,
// request/response beat layouts and the stored entry layout.
// No dependencies.
`default_nettype none

package lkc_pkg;

    // Default table depth
    localparam int unsigned LKC_ENTRIES = 16;

    // Use clock saturates here
    localparam logic [31:0] LKC_STAMP_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_STORE  = 2'd1,
        OP_INVAL  = 2'd2,
        OP_CLEAR  = 2'd3
    } lkc_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE_RD,
        ST_WRITE,
        ST_FINISH
    } lkc_state_t;

    // Request beat
    typedef struct packed {
        lkc_op_t            operation;
        logic [31:0]        key;
        logic signed [63:0] snapshot_in;
        logic [31:0]        handle_in;
        logic [31:0]        size_in;
    } lkc_req_t;

    // Response beat
    typedef struct packed {
        logic               hit;
        logic [3:0]         slot;
        logic signed [63:0] snapshot_out;
        logic [31:0]        handle_out;
        logic [31:0]        size_out;
        logic               released_valid;
        logic [31:0]        released_handle;
        logic [4:0]         entries_used;
    } lkc_rsp_t;

    // One table slot
    typedef struct packed {
        logic [31:0]        key;
        logic signed [63:0] snapshot;
        logic [31:0]        handle;
        logic [31:0]        size;
        logic [31:0]        stamp;
    } lkc_entry_t;

endpackage

`default_nettype wire

// ===== hdl/lkc_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
// Payload type is a parameter; used with types from lkc_pkg.
`default_nettype none

interface lkc_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== hdl/lru_keyed_entry_cache_top.sv =====
// Top level of the fully associative LRU keyed entry cache.
// Depends on lkc_pkg, lkc_stream_if and lkc_table.
//
// The cache holds up to ENTRIES slots, each with a 32-bit key, a signed
// snapshot number, a payload handle, a payload size and a use stamp. One
// request beat gives exactly one response beat. The block takes one request
// at a time: req.ready is high only while the sequencer is idle. A clear
// goes straight from idle to the finish state. Lookup, store and
// invalidate scan the occupied slots through the single read port of the
// entry memory, one slot per cycle, stopping at the first key match. A
// finished response waits in an output register, so a new request may be
// accepted while it is still unclaimed. Only handles are stored; software
// owns the payload buffers and frees the handle reported in
// released_handle.
`default_nettype none

module lru_keyed_entry_cache_top
    import lkc_pkg::*;
#(
    parameter int unsigned ENTRIES = LKC_ENTRIES
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lkc_stream_if.sink    req,
    lkc_stream_if.source  rsp
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    // Sequencer and control state
    lkc_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      use_clock_reg;
    logic [CNT_W-1:0] iss_cnt_reg;
    logic             rd_vld_reg;
    logic             out_vld_reg;

    // Latched request
    lkc_op_t            op_reg;
    logic [31:0]        key_reg;
    logic signed [63:0] snap_reg;
    logic [31:0]        handle_reg;
    logic [31:0]        size_reg;

    // Scan bookkeeping
    logic [IDX_W-1:0] rd_idx_reg;
    logic [31:0]      best_stamp_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_handle_reg;

    // Write-back
    logic [IDX_W-1:0] wr_idx_reg;
    lkc_entry_t       wr_entry_reg;
    logic             move_reg;

    // Response under construction and output register
    logic               res_hit_reg;
    logic [3:0]         res_slot_reg;
    logic signed [63:0] res_snap_reg;
    logic [31:0]        res_handle_reg;
    logic [31:0]        res_size_reg;
    logic               res_rel_v_reg;
    logic [31:0]        res_rel_h_reg;
    lkc_rsp_t           out_data_reg;

    // Table port signals
    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_wr_addr;
    lkc_entry_t       tbl_wr_data;
    logic             tbl_rd_en;
    logic [IDX_W-1:0] tbl_rd_addr;
    lkc_entry_t       tbl_rd_data;

    logic        accept;
    logic        match_now;
    logic        scan_end;
    logic        issue;
    logic        finish_go;
    logic        room;
    logic        move_needed;
    logic [31:0] stamp_new;
    lkc_entry_t  new_entry;

    lkc_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // Handshake and scan conditions
    assign accept    = req.valid && req.ready;
    assign match_now = (state_reg == ST_SCAN) && rd_vld_reg && (tbl_rd_data.key == key_reg);
    assign scan_end  = (state_reg == ST_SCAN) && !rd_vld_reg && !(iss_cnt_reg < count_reg);
    assign issue     = (state_reg == ST_SCAN) && (iss_cnt_reg < count_reg) && !match_now;
    assign finish_go = (state_reg == ST_FINISH) && (!out_vld_reg || rsp.ready);
    assign room      = count_reg < CNT_W'(ENTRIES);
    // Last slot moves into the gap unless the gap is the last slot
    assign move_needed = (CNT_W'(rd_idx_reg) + CNT_W'(1)) < count_reg;

    // Saturating use clock
    assign stamp_new = (use_clock_reg == LKC_STAMP_MAX) ? use_clock_reg
                                                        : use_clock_reg + 32'd1;

    assign new_entry = '{key: key_reg, snapshot: snap_reg, handle: handle_reg,
                         size: size_reg, stamp: stamp_new};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.data.operation == OP_CLEAR) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match_now)
                begin
                    case (op_reg)
                        OP_LOOKUP, OP_STORE: state_next = ST_WRITE;
                        OP_INVAL:            state_next = move_needed ? ST_MOVE_RD : ST_FINISH;
                        default:             state_next = ST_FINISH;
                    endcase
                end
                else if (scan_end)
                begin
                    state_next = (op_reg == OP_STORE) ? ST_WRITE : ST_FINISH;
                end
            end
            ST_MOVE_RD: state_next = ST_WRITE;
            ST_WRITE:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req.ready   = (state_reg == ST_IDLE);
        tbl_rd_en   = issue || (state_reg == ST_MOVE_RD);
        tbl_rd_addr = (state_reg == ST_MOVE_RD) ? count_reg[IDX_W-1:0]
                                                : iss_cnt_reg[IDX_W-1:0];
        tbl_wr_en   = (state_reg == ST_WRITE);
        tbl_wr_addr = wr_idx_reg;
        tbl_wr_data = move_reg ? tbl_rd_data : wr_entry_reg;
        rsp.valid   = out_vld_reg;
        rsp.data    = out_data_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            use_clock_reg <= '0;
            iss_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;

            if (accept)
            begin
                iss_cnt_reg <= '0;
                if (req.data.operation == OP_CLEAR)
                begin
                    count_reg     <= '0;
                    use_clock_reg <= '0;
                end
            end
            else if (issue)
            begin
                iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
            end

            // Stamp and occupancy updates at the end of the scan
            if (match_now)
            begin
                case (op_reg)
                    OP_LOOKUP, OP_STORE: use_clock_reg <= stamp_new;
                    OP_INVAL:            count_reg     <= count_reg - CNT_W'(1);
                    default:             ;
                endcase
            end
            else if (scan_end && (op_reg == OP_STORE))
            begin
                use_clock_reg <= stamp_new;
                if (room)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end

            // Output register
            if (finish_go)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= req.data.operation;
            key_reg        <= req.data.key;
            snap_reg       <= req.data.snapshot_in;
            handle_reg     <= req.data.handle_in;
            size_reg       <= req.data.size_in;
            move_reg       <= 1'b0;
            res_hit_reg    <= 1'b0;
            res_slot_reg   <= '0;
            res_snap_reg   <= '0;
            res_handle_reg <= '0;
            res_size_reg   <= '0;
            res_rel_v_reg  <= 1'b0;
            res_rel_h_reg  <= '0;
        end

        if (issue)
        begin
            rd_idx_reg <= iss_cnt_reg[IDX_W-1:0];
        end

        // Oldest stamp, lowest index on a tie
        if ((state_reg == ST_SCAN) && rd_vld_reg && !match_now)
        begin
            if ((rd_idx_reg == '0) || (tbl_rd_data.stamp < best_stamp_reg))
            begin
                best_stamp_reg  <= tbl_rd_data.stamp;
                best_idx_reg    <= rd_idx_reg;
                best_handle_reg <= tbl_rd_data.handle;
            end
        end

        if (match_now)
        begin
            res_hit_reg  <= 1'b1;
            res_slot_reg <= 4'(rd_idx_reg);
            wr_idx_reg   <= rd_idx_reg;
            case (op_reg)
                OP_LOOKUP:
                begin
                    res_snap_reg   <= tbl_rd_data.snapshot;
                    res_handle_reg <= tbl_rd_data.handle;
                    res_size_reg   <= tbl_rd_data.size;
                    // Same entry, fresh stamp
                    wr_entry_reg   <= '{key:      tbl_rd_data.key,
                                        snapshot: tbl_rd_data.snapshot,
                                        handle:   tbl_rd_data.handle,
                                        size:     tbl_rd_data.size,
                                        stamp:    stamp_new};
                end
                OP_STORE:
                begin
                    res_rel_v_reg <= 1'b1;
                    res_rel_h_reg <= tbl_rd_data.handle;
                    wr_entry_reg  <= new_entry;
                end
                OP_INVAL:
                begin
                    res_rel_v_reg <= 1'b1;
                    res_rel_h_reg <= tbl_rd_data.handle;
                    move_reg      <= 1'b1;
                end
                default: ;
            endcase
        end
        else if (scan_end && (op_reg == OP_STORE))
        begin
            wr_entry_reg <= new_entry;
            if (room)
            begin
                wr_idx_reg   <= count_reg[IDX_W-1:0];
                res_slot_reg <= 4'(count_reg);
            end
            else
            begin
                wr_idx_reg    <= best_idx_reg;
                res_slot_reg  <= 4'(best_idx_reg);
                res_rel_v_reg <= 1'b1;
                res_rel_h_reg <= best_handle_reg;
            end
        end

        if (finish_go)
        begin
            out_data_reg <= '{hit:             res_hit_reg,
                              slot:            res_slot_reg,
                              snapshot_out:    res_snap_reg,
                              handle_out:      res_handle_reg,
                              size_out:        res_size_reg,
                              released_valid:  res_rel_v_reg,
                              released_handle: res_rel_h_reg,
                              entries_used:    5'(count_reg)};
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("occupancy exceeds table depth");

    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.data.operation == OP_CLEAR)) |=>
            (count_reg == '0) && (use_clock_reg == '0))
        else $error("clear did not empty the table");

    a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && (op_reg == OP_STORE)) |=>
            (count_reg >= $past(count_reg)))
        else $error("store reduced occupancy");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (iss_cnt_reg <= count_reg))
        else $error("scan ran past occupied slots");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr_en |-> !tbl_rd_en && (state_next == ST_FINISH))
        else $error("table write overlaps a read");

endmodule

`default_nettype wire

// ===== hdl/lkc_table.sv =====
// Entry memory of the cache: one write port, one read port with
// registered read data. Depends on lkc_pkg for the entry layout.
`default_nettype none

module lkc_table
    import lkc_pkg::*;
#(
    parameter int unsigned ENTRIES = LKC_ENTRIES,
    localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire lkc_entry_t       wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output lkc_entry_t            rd_data
);

    lkc_entry_t mem [ENTRIES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sim/lru_keyed_entry_cache_top_tb.sv =====
// Self-checking testbench for lru_keyed_entry_cache_top: directed and random
// cache requests, a request-level LRU table predictor and a response scoreboard.
// Depends on lkc_pkg, lkc_stream_if and the cache RTL.
`timescale 1ns / 1ps

module lru_keyed_entry_cache_top_tb;
    import lkc_pkg::*;

    localparam int unsigned ENTRIES     = LKC_ENTRIES;
    localparam int          RANDOM_OPS  = 1250;
    localparam int          QUIET_LIMIT = 4000;
    localparam int          STALL_LEN   = 150;
    localparam int          STALL_AT    = 300;
    localparam int          PAUSE_AT    = 700;

    typedef struct {
        lkc_req_t beat;
        bit       drain_first;
    } queued_request_t;

    logic clk;
    logic rst_n;

    lkc_stream_if #(.T(lkc_req_t)) req_ch ();
    lkc_stream_if #(.T(lkc_rsp_t)) rsp_ch ();

    lru_keyed_entry_cache_top #(
        .ENTRIES (ENTRIES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted table contents
    logic [31:0] key_mem    [ENTRIES];
    logic [63:0] snap_mem   [ENTRIES];
    logic [31:0] handle_mem [ENTRIES];
    logic [31:0] size_mem   [ENTRIES];
    logic [31:0] stamp_mem  [ENTRIES];
    int          used_slots = 0;
    logic [31:0] use_clock  = '0;

    queued_request_t request_backlog[$];
    lkc_rsp_t        owed_responses[$];
    logic [31:0]     key_pool[40];
    int              pool_size;

    int requests_taken = 0;
    int responses_seen = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;
    int stall_left     = 0;
    bit stall_done     = 0;
    bit req_taken      = 0;

    // Idle-free window in the middle of the random part
    wire steady_stretch = (requests_taken >= 500) && (requests_taken < 650);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] bump_clock();
        if (use_clock != LKC_STAMP_MAX)
            use_clock = use_clock + 1;
        return use_clock;
    endfunction

    // Next response of the cache; updates the predicted table
    function automatic lkc_rsp_t lru_cache_response(lkc_req_t rq);
        lkc_rsp_t rs;
        int       idx;
        int       last;
        rs  = '0;
        idx = -1;
        for (int i = 0; i < used_slots; i++)
        begin
            if (idx < 0 && key_mem[i] == rq.key)
                idx = i;
        end
        case (rq.operation)
            OP_LOOKUP:
            begin
                if (idx >= 0)
                begin
                    stamp_mem[idx]  = bump_clock();
                    rs.hit          = 1'b1;
                    rs.slot         = idx[3:0];
                    rs.snapshot_out = snap_mem[idx];
                    rs.handle_out   = handle_mem[idx];
                    rs.size_out     = size_mem[idx];
                end
            end
            OP_STORE:
            begin
                if (idx >= 0)
                begin
                    rs.hit             = 1'b1;
                    rs.released_valid  = 1'b1;
                    rs.released_handle = handle_mem[idx];
                end
                else if (used_slots < ENTRIES)
                begin
                    idx        = used_slots;
                    used_slots = used_slots + 1;
                end
                else
                begin
                    // evict oldest stamp, lowest index wins a tie
                    idx = 0;
                    for (int i = 1; i < ENTRIES; i++)
                    begin
                        if (stamp_mem[i] < stamp_mem[idx])
                            idx = i;
                    end
                    rs.released_valid  = 1'b1;
                    rs.released_handle = handle_mem[idx];
                end
                key_mem[idx]    = rq.key;
                snap_mem[idx]   = rq.snapshot_in;
                handle_mem[idx] = rq.handle_in;
                size_mem[idx]   = rq.size_in;
                stamp_mem[idx]  = bump_clock();
                rs.slot         = idx[3:0];
            end
            OP_INVAL:
            begin
                if (idx >= 0)
                begin
                    last               = used_slots - 1;
                    rs.hit             = 1'b1;
                    rs.slot            = idx[3:0];
                    rs.released_valid  = 1'b1;
                    rs.released_handle = handle_mem[idx];
                    // last slot fills the gap
                    if (idx < last)
                    begin
                        key_mem[idx]    = key_mem[last];
                        snap_mem[idx]   = snap_mem[last];
                        handle_mem[idx] = handle_mem[last];
                        size_mem[idx]   = size_mem[last];
                        stamp_mem[idx]  = stamp_mem[last];
                    end
                    used_slots = last;
                end
            end
            default:
            begin
                used_slots = 0;
                use_clock  = '0;
            end
        endcase
        rs.entries_used = used_slots[4:0];
        return rs;
    endfunction

    task automatic add_request(lkc_op_t op, logic [31:0] key, logic [63:0] snap,
                               logic [31:0] handle, logic [31:0] size, bit drain);
        queued_request_t qr;
        qr.beat.operation   = op;
        qr.beat.key         = key;
        qr.beat.snapshot_in = snap;
        qr.beat.handle_in   = handle;
        qr.beat.size_in     = size;
        qr.drain_first      = drain;
        request_backlog.push_back(qr);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Request driver: new beats at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            if (request_backlog.size() > 0
                && !(request_backlog[0].drain_first && owed_responses.size() > 0)
                && (steady_stretch || $urandom_range(0, 99) >= 36))
            begin
                req_ch.data  <= request_backlog[0].beat;
                req_ch.valid <= 1'b1;
                request_backlog.delete(0);
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response sink: random back-pressure plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!stall_done && responses_seen >= STALL_AT)
            begin
                stall_left = STALL_LEN;
                stall_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= steady_stretch || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    // Monitor: predict on request beats, check response beats, watchdog
    always @(posedge clk)
    begin
        lkc_rsp_t want;
        bit       rsp_taken;
        req_taken = req_ch.valid && req_ch.ready;
        rsp_taken = rsp_ch.valid && rsp_ch.ready;
        if (rsp_taken)
        begin
            responses_seen++;
            if (owed_responses.size() == 0)
            begin
                $error("response beat with nothing outstanding");
                fail_count++;
            end
            else
            begin
                want = owed_responses.pop_front();
                check_field("hit", want.hit, rsp_ch.data.hit);
                check_field("slot", want.slot, rsp_ch.data.slot);
                check_field("snapshot_out", want.snapshot_out, rsp_ch.data.snapshot_out);
                check_field("handle_out", want.handle_out, rsp_ch.data.handle_out);
                check_field("size_out", want.size_out, rsp_ch.data.size_out);
                check_field("released_valid", want.released_valid,
                            rsp_ch.data.released_valid);
                check_field("released_handle", want.released_handle,
                            rsp_ch.data.released_handle);
                check_field("entries_used", want.entries_used, rsp_ch.data.entries_used);
            end
        end
        if (req_taken)
        begin
            owed_responses.push_back(lru_cache_response(req_ch.data));
            requests_taken++;
        end
        if (req_taken || rsp_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        lkc_op_t     op;
        int unsigned pick;
        logic [31:0] key;
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;

        // Directed: empty table, extremes, fill, hit, update, evict, removal
        add_request(OP_CLEAR, '0, '0, '0, '0, 1'b0);
        add_request(OP_LOOKUP, 32'h0, '1, '1, '1, 1'b0);
        add_request(OP_INVAL, 32'hFFFF_FFFF, '0, '0, '0, 1'b0);
        add_request(OP_STORE, 32'h0, 64'h8000_0000_0000_0000, 32'h0, 32'hFFFF_FFFF, 1'b0);
        add_request(OP_STORE, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                    32'h0, 1'b0);
        for (int i = 0; i < 14; i++)
            add_request(OP_STORE, 32'h100 + i, {$urandom, $urandom}, $urandom, $urandom,
                        1'b0);
        add_request(OP_LOOKUP, 32'h0, '0, '0, '0, 1'b0);
        add_request(OP_STORE, 32'hFFFF_FFFF, '1, 32'h1234_5678, 32'h40, 1'b0);
        add_request(OP_STORE, 32'hDEAD_BEEF, {$urandom, $urandom}, $urandom, $urandom, 1'b0);
        add_request(OP_INVAL, 32'h0, '0, '0, '0, 1'b0);
        add_request(OP_INVAL, 32'h10C, '0, '0, '0, 1'b0);
        add_request(OP_LOOKUP, 32'h0, '0, '0, '0, 1'b0);
        add_request(OP_CLEAR, '1, '1, '1, '1, 1'b0);

        // Random: keys from a small pool so hits and evictions are common
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 250 == 0)
            begin
                pool_size = $urandom_range(8, 40);
                foreach (key_pool[k])
                    key_pool[k] = $urandom;
            end
            pick = $urandom_range(0, 99);
            if (pick < 38)
                op = OP_LOOKUP;
            else if (pick < 78)
                op = OP_STORE;
            else if (pick < 99)
                op = OP_INVAL;
            else
                op = OP_CLEAR;
            if ($urandom_range(0, 19) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, pool_size - 1)];
            add_request(op, key, {$urandom, $urandom}, $urandom, $urandom,
                        (n == 0) || (n == PAUSE_AT));
        end

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Drain and let stray beats show up
        while (request_backlog.size() > 0 || req_ch.valid)
            @(posedge clk);
        while (owed_responses.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
